// ----- hw/rtl/crcp_pkg.sv -----
// shared types, constants and helpers for the crc codeword packer
`timescale 1ns / 1ps

package crcp_pkg;

  // default sizes
  localparam int MAX_GEN_LEN_DEF = 9;
  localparam int COUNT_WIDTH_DEF = 24;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GEN_BITS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GEN_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_MODE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BYTE_CNT  = 2'd3;

  // configuration reset values
  localparam int         GEN_BITS_RST = 13;
  localparam logic [3:0] GEN_LEN_RST  = 4'd4;
  localparam logic       WORD_MODE_RST = 1'b1;
  localparam int         BYTE_CNT_RST = 1;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // at most this many output bytes per input transaction
  localparam int MAX_RESULTS = 5;
  localparam int NB_W = 3;

  // control part of one queued job
  typedef struct packed {
    logic            hdr;        // send header byte first
    logic [3:0]      pad;        // pad count carried in the header
    logic            frame_end;  // job closes the frame
    logic [NB_W-1:0] nbytes;     // data bytes taken from the bit field
  } job_ctl_t;

  // bit field width: leftover (7) + pad (8) + two codewords of max_gen_len+3
  function automatic int stream_w(input int max_gen_len);
    return 2 * max_gen_len + 21;
  endfunction

endpackage

// ----- hw/rtl/crcp_fifo.sv -----
// small first-word-fall-through queue between front and back
`timescale 1ns / 1ps

module crcp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = crcp_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output logic [WIDTH-1:0] head_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;

  assign full       = (cnt_r == CNTW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/crcp_front.sv -----
// front: crc of each dataword, header and pad planning, bit assembly into jobs
`timescale 1ns / 1ps

module crcp_front #(
  parameter int MAX_GEN_LEN = crcp_pkg::MAX_GEN_LEN_DEF,
  parameter int COUNT_WIDTH = crcp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [7:0]                    in_data_byte,
  input  logic                          q_full,
  output logic                          q_push,
  output crcp_pkg::job_ctl_t            q_ctl,
  output logic [crcp_pkg::stream_w(MAX_GEN_LEN)-1:0] q_bits,
  input  logic [MAX_GEN_LEN-1:0]        cfg_gen,
  input  logic [3:0]                    cfg_glen,
  input  logic                          cfg_mode,
  input  logic [COUNT_WIDTH-1:0]        cfg_bcount
);

  import crcp_pkg::*;

  localparam int REMW = MAX_GEN_LEN - 1;
  localparam int GLW  = $clog2(MAX_GEN_LEN + 1);
  localparam int TW   = stream_w(MAX_GEN_LEN);
  localparam int TCW  = $clog2(TW + 1);

  // bit-serial long division, data left aligned, n bits used
  function automatic logic [REMW-1:0] crc_rem(
    input logic [7:0]      d,
    input logic [3:0]      n,
    input logic [REMW-1:0] poly,
    input logic [REMW-1:0] mask,
    input logic [REMW-1:0] top
  );
    logic [REMW-1:0] r;
    logic            fb;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (i < int'(n)) begin
        fb = d[7-i] ^ (|(r & top));
        r  = ((r << 1) ^ (fb ? poly : '0)) & mask;
      end
    end
    return r;
  endfunction

  logic [GLW-1:0]         g;
  logic [REMW-1:0]        rem_mask, top_mask, poly;
  logic [REMW-1:0]        rem8, remh, reml;
  logic [TCW-1:0]         gm1, n4, cwlen, peff, total, full_n, dcount, lim;
  logic [TW-1:0]          cw8, cwh, cwl, cw4, cw, vbits;
  logic [5:0]             prod;
  logic [3:0]             pad;
  logic                   hdr, frame_end, accept;
  logic [2:0]             rm;
  logic [COUNT_WIDTH-1:0] bseen_inc;

  logic                   hdr_sent_r, hdr_sent_nxt;
  logic [COUNT_WIDTH-1:0] bytes_seen_r, bytes_seen_nxt;
  logic [6:0]             lo_bits_r, lo_bits_nxt;
  logic [2:0]             lo_cnt_r, lo_cnt_nxt;

  // clamp generator length into its legal range
  always_comb begin
    if (cfg_glen < 4'd2) begin
      g = GLW'(2);
    end else if (int'(cfg_glen) > MAX_GEN_LEN) begin
      g = GLW'(MAX_GEN_LEN);
    end else begin
      g = GLW'(cfg_glen);
    end
  end

  assign rem_mask = ~({REMW{1'b1}} << (g - GLW'(1)));
  assign top_mask = REMW'(1) << (g - GLW'(2));
  assign poly     = cfg_gen[REMW-1:0] & rem_mask;

  assign rem8 = crc_rem(in_data_byte, 4'd8, poly, rem_mask, top_mask);
  assign remh = crc_rem({in_data_byte[7:4], 4'b0000}, 4'd4, poly, rem_mask, top_mask);
  assign reml = crc_rem({in_data_byte[3:0], 4'b0000}, 4'd4, poly, rem_mask, top_mask);

  assign gm1 = TCW'(g) - TCW'(1);
  assign n4  = TCW'(g) + TCW'(3);
  assign cw8 = (TW'(in_data_byte) << gm1) | TW'(rem8);
  assign cwh = (TW'(in_data_byte[7:4]) << gm1) | TW'(remh);
  assign cwl = (TW'(in_data_byte[3:0]) << gm1) | TW'(reml);
  assign cw4 = (cwh << n4) | cwl;

  assign cw    = cfg_mode ? cw8 : cw4;
  assign cwlen = cfg_mode ? (TCW'(g) + TCW'(7)) : (n4 + n4);

  // pad = 8 - (frame length mod 8), only low 3 bits of each factor matter
  assign prod = {3'b000, cfg_bcount[2:0]} * {3'b000, cwlen[2:0]};
  assign pad  = 4'd8 - {1'b0, prod[2:0]};

  assign hdr    = !hdr_sent_r;
  assign peff   = hdr ? TCW'(pad) : '0;
  assign total  = TCW'(lo_cnt_r) + peff + cwlen;
  assign vbits  = (TW'(lo_bits_r) << (peff + cwlen)) | cw;
  assign full_n = total >> 3;
  assign rm     = total[2:0];

  assign bseen_inc = bytes_seen_r + 1'b1;
  assign frame_end = (bseen_inc == cfg_bcount);

  // flush byte when pending bits remain at frame end, then cap the count
  assign dcount = full_n + TCW'(frame_end && (rm != 3'd0));
  assign lim    = hdr ? TCW'(MAX_RESULTS - 1) : TCW'(MAX_RESULTS);

  assign accept = in_valid && !q_full;
  assign q_push = accept;

  always_comb begin
    q_ctl.hdr       = hdr;
    q_ctl.pad       = pad;
    q_ctl.frame_end = frame_end;
    q_ctl.nbytes    = (dcount > lim) ? NB_W'(lim) : NB_W'(dcount);
  end

  // left align so the back only ever shifts by a byte
  assign q_bits = vbits << (TCW'(TW) - total);

  always_comb begin
    hdr_sent_nxt   = hdr_sent_r;
    bytes_seen_nxt = bytes_seen_r;
    lo_bits_nxt    = lo_bits_r;
    lo_cnt_nxt     = lo_cnt_r;
    if (accept) begin
      if (frame_end) begin
        hdr_sent_nxt   = 1'b0;
        bytes_seen_nxt = '0;
        lo_bits_nxt    = '0;
        lo_cnt_nxt     = '0;
      end else begin
        hdr_sent_nxt   = 1'b1;
        bytes_seen_nxt = bseen_inc;
        lo_bits_nxt    = vbits[6:0] & ~(7'h7f << rm);
        lo_cnt_nxt     = rm;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_sent_r   <= 1'b0;
      bytes_seen_r <= '0;
      lo_bits_r    <= '0;
      lo_cnt_r     <= '0;
    end else begin
      hdr_sent_r   <= hdr_sent_nxt;
      bytes_seen_r <= bytes_seen_nxt;
      lo_bits_r    <= lo_bits_nxt;
      lo_cnt_r     <= lo_cnt_nxt;
    end
  end

endmodule

// ----- hw/rtl/crcp_back.sv -----
// back: drains queued jobs into the output register, one byte per cycle unless stalled
`timescale 1ns / 1ps

module crcp_back #(
  parameter int STREAM_W = crcp_pkg::stream_w(crcp_pkg::MAX_GEN_LEN_DEF)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  crcp_pkg::job_ctl_t q_ctl,
  input  logic [STREAM_W-1:0] q_bits,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               out_run_last,
  output logic               out_frame_last
);

  import crcp_pkg::*;

  logic                busy_r, busy_nxt;
  logic [STREAM_W-1:0] bits_r, bits_nxt;
  logic [NB_W-1:0]     cnt_r, cnt_nxt;
  logic                fe_r, fe_nxt;

  logic                ov_r, ov_nxt;
  logic [7:0]          ob_r, ob_nxt;
  logic                orl_r, orl_nxt;
  logic                ofl_r, ofl_nxt;

  logic                cur_valid, adv, emit_hdr, src_fe, last;
  logic [STREAM_W-1:0] src_bits, rest_bits;
  logic [NB_W-1:0]     src_cnt, rest_cnt;
  logic [7:0]          cur_byte;

  assign cur_valid = busy_r || q_valid;
  assign adv       = cur_valid && (!ov_r || !out_stall);
  assign q_pop     = adv && !busy_r;

  // header only ever leaves straight from the queue head
  assign emit_hdr = !busy_r && q_ctl.hdr;
  assign src_bits = busy_r ? bits_r : q_bits;
  assign src_cnt  = busy_r ? cnt_r : q_ctl.nbytes;
  assign src_fe   = busy_r ? fe_r : q_ctl.frame_end;

  assign cur_byte  = emit_hdr ? {4'b0000, q_ctl.pad} : src_bits[STREAM_W-1 -: 8];
  assign rest_bits = emit_hdr ? src_bits : (src_bits << 8);
  assign rest_cnt  = emit_hdr ? src_cnt : (src_cnt - 1'b1);
  assign last      = (rest_cnt == '0);

  always_comb begin
    busy_nxt = busy_r;
    bits_nxt = bits_r;
    cnt_nxt  = cnt_r;
    fe_nxt   = fe_r;
    ov_nxt   = ov_r && out_stall;
    ob_nxt   = ob_r;
    orl_nxt  = orl_r;
    ofl_nxt  = ofl_r;
    if (adv) begin
      busy_nxt = !last;
      bits_nxt = rest_bits;
      cnt_nxt  = rest_cnt;
      fe_nxt   = src_fe;
      ov_nxt   = 1'b1;
      ob_nxt   = cur_byte;
      orl_nxt  = last;
      ofl_nxt  = last && src_fe;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bits_r <= bits_nxt;
    cnt_r  <= cnt_nxt;
    fe_r   <= fe_nxt;
    ob_r   <= ob_nxt;
    orl_r  <= orl_nxt;
    ofl_r  <= ofl_nxt;
  end

  assign out_valid      = ov_r;
  assign out_byte       = ob_r;
  assign out_run_last   = orl_r;
  assign out_frame_last = ofl_r;

  a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_busy_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0))
    else $error("active job with nothing left to send");

  a_frame_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ofl_r) |-> orl_r)
    else $error("frame end not on the last byte of a transaction");

  a_last_frees_back: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && last) |=> !busy_r)
    else $error("back still busy after the last byte of a job");

endmodule

// ----- hw/rtl/crc_codeword_packer.sv -----
// top level of the crc codeword packer: config registers, front, queue, back
`timescale 1ns / 1ps

// crc codeword packer
// input channel: one data byte per transaction (in_valid / in_stall)
// each byte is split into datawords (two nibbles high first, or the whole
// byte), each dataword is followed by its crc remainder from mod-2 long
// division by the configured generator, and the codeword bits are packed
// msb first into bytes on the output channel (out_valid / out_stall)
// the first byte of a frame first sends a header byte with the pad count,
// then that many zero pad bits; at frame end pending bits are flushed
// one input transaction gives 1 to 5 output bytes; out_run_last marks the
// last of them and out_frame_last the final byte of the frame
// the first output byte passes through the job queue and then the output
// register; the back sends one byte per cycle while the output is not
// stalled, and the number of output bytes of an input is set by the
// codeword length, the pending bits and the header; the front takes a new
// byte every cycle while the job queue has room
// reset (synchronous, active low) empties the queue and output register,
// starts a new frame and loads the default configuration
// a stalled receiver holds the output byte; the queue then fills and
// in_stall rises; the user must write config only while idle (not enforced)
module crc_codeword_packer #(
  parameter int MAX_GEN_LEN = crcp_pkg::MAX_GEN_LEN_DEF,
  parameter int COUNT_WIDTH = crcp_pkg::COUNT_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_data_byte,
  // output channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          out_byte,
  output logic                                out_run_last,
  output logic                                out_frame_last,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [crcp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [((COUNT_WIDTH > MAX_GEN_LEN) ? COUNT_WIDTH : MAX_GEN_LEN)-1:0] cfg_wdata
);

  import crcp_pkg::*;

  localparam int TW = stream_w(MAX_GEN_LEN);
  localparam int QW = $bits(job_ctl_t) + TW;

  // configuration registers
  logic [MAX_GEN_LEN-1:0] gen_r;
  logic [3:0]             glen_r;
  logic                   mode_r;
  logic [COUNT_WIDTH-1:0] bcount_r;

  // front to queue
  logic          push, q_full;
  job_ctl_t      f_ctl;
  logic [TW-1:0] f_bits;

  // queue to back
  logic          pop, head_valid;
  logic [QW-1:0] head_data;
  job_ctl_t      b_ctl;
  logic [TW-1:0] b_bits;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r    <= MAX_GEN_LEN'(GEN_BITS_RST);
      glen_r   <= GEN_LEN_RST;
      mode_r   <= WORD_MODE_RST;
      bcount_r <= COUNT_WIDTH'(BYTE_CNT_RST);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GEN_BITS:  gen_r    <= cfg_wdata[MAX_GEN_LEN-1:0];
        REG_GEN_LEN:   glen_r   <= cfg_wdata[3:0];
        REG_WORD_MODE: mode_r   <= cfg_wdata[0];
        REG_BYTE_CNT:  bcount_r <= cfg_wdata[COUNT_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // input stalls only when the job queue is full
  assign in_stall = q_full;

  // crc, padding and bit assembly; one transaction per cycle while the queue has room
  crcp_front #(
    .MAX_GEN_LEN (MAX_GEN_LEN),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .q_push       (push),
    .q_ctl        (f_ctl),
    .q_bits       (f_bits),
    .cfg_gen      (gen_r),
    .cfg_glen     (glen_r),
    .cfg_mode     (mode_r),
    .cfg_bcount   (bcount_r)
  );

  // job queue decouples the front from a stalled back
  crcp_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  ({f_ctl, f_bits}),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  assign b_ctl  = head_data[QW-1 -: $bits(job_ctl_t)];
  assign b_bits = head_data[TW-1:0];

  // byte serializer with the output register
  crcp_back #(
    .STREAM_W (TW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (head_valid),
    .q_ctl          (b_ctl),
    .q_bits         (b_bits),
    .q_pop          (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_frame_last (out_frame_last)
  );

endmodule
